### src/cft_pkg.sv
// Shared types and constants for the CSV field tokenizer.
// No dependencies; used by every module under src.
package cft_pkg;

    localparam int unsigned MAX_LEN_W   = 16;
    localparam int unsigned LINE_W      = 32;
    localparam int unsigned CHAR_W      = 8;

    localparam logic [CHAR_W-1:0]    QUOTE_CHAR   = 8'h22;
    localparam logic [CHAR_W-1:0]    COMMA_CHAR   = 8'h2C;
    localparam logic [CHAR_W-1:0]    NEWLINE_CHAR = 8'h0A;
    localparam logic [CHAR_W-1:0]    NUL_CHAR     = 8'h00;
    localparam logic [MAX_LEN_W-1:0] DEFAULT_MAX_FIELD = 16'd2000;
    localparam logic [LINE_W-1:0]    LINE_START   = 32'd1;
    localparam logic [LINE_W-1:0]    LINE_MAX     = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        KIND_DATA      = 3'd0,
        KIND_FIELD_END = 3'd1,
        KIND_ROW_END   = 3'd2,
        KIND_INPUT_END = 3'd3,
        KIND_TOO_LONG  = 3'd4
    } kind_t;

    typedef struct packed {
        logic              eoi;
        logic [CHAR_W-1:0] data;
    } in_item_t;

    typedef struct packed {
        logic              valid;
        kind_t             kind;
        logic [CHAR_W-1:0] data;
        logic [LINE_W-1:0] line;
    } result_t;

endpackage

### src/csv_field_tokenizer.sv
// CSV field tokenizer: takes one text byte per beat and returns content bytes, field ends,
// row ends, input end and a sticky too-long error, each with the line number after the byte.
// One byte per clock sustained unless m_axis_tready back-pressures; a byte enters an input
// register and its result, if any, then leaves the result register. The rate is set by the single
// registered update of the quote, length and line state. The field length limit
// (cfg_wr_data, reset 2000) must be written only while the block is idle.
// Depends on cft_pkg, cft_in_stage, cft_step, cft_out_stage.
module csv_field_tokenizer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,     // max_field_length
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // [7:0] in_byte
    input  logic        s_axis_tlast,    // end_of_input
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,    // [7:0] out_byte, [39:8] line_number
    output logic [2:0]  m_axis_tuser     // [2:0] kind
);

    logic [cft_pkg::MAX_LEN_W-1:0] max_len_reg;
    cft_pkg::in_item_t             in_item;
    cft_pkg::in_item_t             item;
    cft_pkg::result_t              result;
    cft_pkg::kind_t                out_kind;
    logic [cft_pkg::CHAR_W-1:0]    out_data;
    logic [cft_pkg::LINE_W-1:0]    out_line;
    logic                          item_valid;
    logic                          out_free;
    logic                          advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= cft_pkg::DEFAULT_MAX_FIELD;
        end
        else if (cfg_wr_en)
        begin
            max_len_reg <= cfg_wr_data;
        end
    end

    assign in_item.eoi  = s_axis_tlast;
    assign in_item.data = s_axis_tdata;
    assign advance      = item_valid && out_free;

    cft_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    cft_step u_step
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item),
        .max_len (max_len_reg),
        .result  (result)
    );

    cft_out_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .result    (result),
        .out_free  (out_free),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_kind  (out_kind),
        .out_data  (out_data),
        .out_line  (out_line)
    );

    assign m_axis_tdata = {out_line, out_data};
    assign m_axis_tuser = out_kind;

`ifndef SYNTHESIS
    // only content beats carry a byte
    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser != cft_pkg::KIND_DATA) |-> (m_axis_tdata[7:0] == 8'd0))
        else $error("non-content beat carries a byte");

    // line number is never zero
    a_line_nz: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[39:8] != 32'd0))
        else $error("line number zero");
`endif

endmodule

### src/cft_in_stage.sv
// Input register stage of the CSV field tokenizer.
// Depends on cft_pkg.
module cft_in_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  cft_pkg::in_item_t in_item,
    input  logic              advance,
    output logic              item_valid,
    output cft_pkg::in_item_t item
);

    logic              valid_reg;
    logic              valid_next;
    cft_pkg::in_item_t item_reg;

    assign in_ready   = !valid_reg || advance;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

### src/cft_step.sv
// Tokenizer state and per-byte update logic.
// Depends on cft_pkg.
module cft_step
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            advance,
    input  cft_pkg::in_item_t               item,
    input  logic [cft_pkg::MAX_LEN_W-1:0]   max_len,
    output cft_pkg::result_t                result
);

    logic                          inq_reg, inq_next;
    logic                          pend_reg, pend_next;
    logic [cft_pkg::MAX_LEN_W-1:0] fb_reg, fb_next;
    logic [cft_pkg::LINE_W-1:0]    line_reg, line_next;
    logic                          failed_reg, failed_next;

    logic                          is_end;
    logic                          is_quote;
    logic                          fall;
    logic                          inq_eff;
    logic                          res_valid;
    cft_pkg::kind_t                res_kind;

    assign is_end   = item.eoi || (item.data == cft_pkg::NUL_CHAR);
    assign is_quote = (item.data == cft_pkg::QUOTE_CHAR);

    always_comb
    begin
        inq_next    = inq_reg;
        pend_next   = pend_reg;
        fb_next     = fb_reg;
        line_next   = line_reg;
        failed_next = failed_reg;
        res_valid   = 1'b0;
        res_kind    = cft_pkg::KIND_DATA;
        fall        = 1'b0;
        inq_eff     = inq_reg;

        if (failed_reg)
        begin
            res_valid = 1'b1;
            res_kind  = cft_pkg::KIND_TOO_LONG;
        end
        else
        begin
            if (pend_reg)
            begin
                pend_next = 1'b0;
                priority if (is_end)
                begin
                    inq_next  = 1'b0;
                    fb_next   = '0;
                    res_valid = 1'b1;
                    res_kind  = cft_pkg::KIND_INPUT_END;
                end
                else if (is_quote)
                begin
                    // doubled quote: one literal quote, not length-checked
                    fb_next   = fb_reg + 1'b1;
                    res_valid = 1'b1;
                    res_kind  = cft_pkg::KIND_DATA;
                end
                else
                begin
                    inq_next = 1'b0;
                    inq_eff  = 1'b0;
                    fall     = 1'b1;
                end
            end
            else
            begin
                priority if (fb_reg >= max_len)
                begin
                    failed_next = 1'b1;
                    res_valid   = 1'b1;
                    res_kind    = cft_pkg::KIND_TOO_LONG;
                end
                else if (is_end)
                begin
                    inq_next  = 1'b0;
                    fb_next   = '0;
                    res_valid = 1'b1;
                    res_kind  = cft_pkg::KIND_INPUT_END;
                end
                else if (is_quote && inq_reg)
                begin
                    pend_next = 1'b1;
                end
                else if (is_quote && (fb_reg == '0))
                begin
                    inq_next = 1'b1;
                end
                else
                begin
                    fall = 1'b1;
                end
            end

            if (fall)
            begin
                priority if (!inq_eff && (item.data == cft_pkg::COMMA_CHAR))
                begin
                    inq_next  = 1'b0;
                    fb_next   = '0;
                    res_valid = 1'b1;
                    res_kind  = cft_pkg::KIND_FIELD_END;
                end
                else
                begin
                    // quoted newlines are data but still count as lines
                    if ((item.data == cft_pkg::NEWLINE_CHAR) && (line_reg != cft_pkg::LINE_MAX))
                    begin
                        line_next = line_reg + 1'b1;
                    end
                    res_valid = 1'b1;
                    if (!inq_eff && (item.data == cft_pkg::NEWLINE_CHAR))
                    begin
                        inq_next = 1'b0;
                        fb_next  = '0;
                        res_kind = cft_pkg::KIND_ROW_END;
                    end
                    else
                    begin
                        fb_next  = fb_reg + 1'b1;
                        res_kind = cft_pkg::KIND_DATA;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inq_reg    <= 1'b0;
            pend_reg   <= 1'b0;
            fb_reg     <= '0;
            line_reg   <= cft_pkg::LINE_START;
            failed_reg <= 1'b0;
        end
        else if (advance)
        begin
            inq_reg    <= inq_next;
            pend_reg   <= pend_next;
            fb_reg     <= fb_next;
            line_reg   <= line_next;
            failed_reg <= failed_next;
        end
    end

    always_comb
    begin
        result.valid = res_valid;
        result.kind  = res_kind;
        result.data  = (res_kind == cft_pkg::KIND_DATA) ? item.data : '0;
        result.line  = line_next;
    end

`ifndef SYNTHESIS
    // the error is sticky until reset
    a_failed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        failed_reg |=> failed_reg)
        else $error("failed flag cleared without reset");

    // once failed, every beat reports too long
    a_failed_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (failed_reg && advance) |-> (result.valid && result.kind == cft_pkg::KIND_TOO_LONG))
        else $error("beat after failure not reported as too long");

    // line count never goes backward
    a_line_mono: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (line_reg >= $past(line_reg)))
        else $error("line count decreased");

    // a pending quote only exists inside a quoted field
    a_pend_inq: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> inq_reg)
        else $error("quote pending outside quotes");
`endif

endmodule

### src/cft_out_stage.sv
// Result register stage of the CSV field tokenizer.
// Depends on cft_pkg.
module cft_out_stage
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  cft_pkg::result_t result,
    output logic             out_free,
    output logic             out_valid,
    input  logic             out_ready,
    output cft_pkg::kind_t   out_kind,
    output logic [cft_pkg::CHAR_W-1:0] out_data,
    output logic [cft_pkg::LINE_W-1:0] out_line
);

    logic             valid_reg;
    logic             valid_next;
    cft_pkg::result_t res_reg;

    assign out_free = !valid_reg || out_ready;

    always_comb
    begin
        if (load)
        begin
            valid_next = result.valid;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && result.valid)
        begin
            res_reg <= result;
        end
    end

    assign out_valid = valid_reg;
    assign out_kind  = res_reg.kind;
    assign out_data  = res_reg.data;
    assign out_line  = res_reg.line;

endmodule
